### sv/pxu_pkg.sv
// Shared types, constants and codes for the packed 10-bit pixel unpacker.
package pxu_pkg;

  // Frame geometry limits and group layout
  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned MaxHeight  = 2048;
  localparam int unsigned GroupBytes = 5;
  localparam int unsigned RstWidth   = 640;
  localparam int unsigned RstHeight  = 480;

  // Field and datapath widths
  localparam int unsigned DimW     = 12;
  localparam int unsigned ExtraW   = 7;
  localparam int unsigned PixW     = 10;
  localparam int unsigned GrayW    = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 22;
  localparam int unsigned LimitW   = 2 * DimW;
  localparam int unsigned ExpW     = 27;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OUT_MODE     = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2,
    CFG_EXTRA_ROWS   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_DATA = 1'b0,
    REQ_EOF  = 1'b1
  } req_type_e;

  typedef enum logic {
    RES_PIXEL  = 1'b0,
    RES_STATUS = 1'b1
  } res_kind_e;

  typedef enum logic {
    OP_GROUP = 1'b0,
    OP_EOF   = 1'b1
  } op_e;

  // Input item
  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] data_byte;
  } in_t;

  // Result item
  typedef struct packed {
    logic              result_kind;
    logic [PixW-1:0]   pixel_value;
    logic [GrayW-1:0]  gray_byte;
    logic              leftover_error;
    logic              size_error;
    logic [CountW-1:0] received_pixels;
    logic              last;
  } out_t;

  // Work entry handed from front to back
  typedef struct packed {
    op_e                  op;
    logic [3:0][PixW-1:0] pixels;
    logic                 leftover;
  } qentry_t;

endpackage

### sv/packed_10bit_pixel_unpacker.sv
// Packed 10-bit pixel unpacker top level: configuration registers and unit wiring.
//
// Takes one stream byte or end-of-frame event per cycle while not stalled. Every
// fifth data byte completes a group; its four pixels leave the back end one per
// cycle while the output is not stalled, and pixels past the frame size are
// dropped. The input runs at one item per cycle without stalling while the output
// is taken. An end-of-frame event yields one status result. A four-entry queue
// between the byte assembler and the pixel emitter absorbs output stalls; the
// input stalls only when that queue is full. Results pass through that queue and
// then the output register. Configuration registers are read as each queued entry
// reaches the back end; the frame size products are registered from the dimension
// registers in the cycle after them.
module packed_10bit_pixel_unpacker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pxu_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pxu_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pxu_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pxu_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  logic                              out_mode_q;
  logic [pxu_pkg::DimW-1:0]          frame_width_q, frame_height_q;
  logic [pxu_pkg::ExtraW-1:0]        extra_rows_q;
  logic [pxu_pkg::DimW-1:0]          eff_w, eff_h;
  logic [pxu_pkg::DimW:0]            h_adj;
  logic [pxu_pkg::LimitW-1:0]        limit_q, limit_d;
  logic [pxu_pkg::ExpW-1:0]          expected_q, expected_d;

  logic                              push, q_full, q_valid, pop;
  pxu_pkg::qentry_t                  entry, head;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_mode_q     <= 1'b0;
      frame_width_q  <= pxu_pkg::DimW'(pxu_pkg::RstWidth);
      frame_height_q <= pxu_pkg::DimW'(pxu_pkg::RstHeight);
      extra_rows_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pxu_pkg::CFG_OUT_MODE:     out_mode_q     <= cfg_wdata_i[0];
        pxu_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        pxu_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        pxu_pkg::CFG_EXTRA_ROWS:   extra_rows_q   <= cfg_wdata_i[pxu_pkg::ExtraW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped dimensions, emit limit and expected count
  assign eff_w = (frame_width_q > pxu_pkg::DimW'(pxu_pkg::MaxWidth))
                 ? pxu_pkg::DimW'(pxu_pkg::MaxWidth) : frame_width_q;
  assign eff_h = (frame_height_q > pxu_pkg::DimW'(pxu_pkg::MaxHeight))
                 ? pxu_pkg::DimW'(pxu_pkg::MaxHeight) : frame_height_q;
  assign h_adj = {1'b0, eff_h}
               + {{(pxu_pkg::DimW + 1 - pxu_pkg::ExtraW){extra_rows_q[pxu_pkg::ExtraW-1]}},
                  extra_rows_q};
  assign limit_d = {{(pxu_pkg::LimitW - pxu_pkg::DimW){1'b0}}, eff_w}
                 * {{(pxu_pkg::LimitW - pxu_pkg::DimW){1'b0}}, eff_h};
  assign expected_d = $unsigned(
      $signed({{(pxu_pkg::ExpW - pxu_pkg::DimW){1'b0}}, eff_w})
    * $signed({{(pxu_pkg::ExpW - pxu_pkg::DimW - 1){h_adj[pxu_pkg::DimW]}}, h_adj}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= pxu_pkg::LimitW'(pxu_pkg::RstWidth * pxu_pkg::RstHeight);
      expected_q <= pxu_pkg::ExpW'(pxu_pkg::RstWidth * pxu_pkg::RstHeight);
    end else begin
      limit_q    <= limit_d;
      expected_q <= expected_d;
    end
  end

  pxu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (entry)
  );

  pxu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  pxu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_mode_i  (out_mode_q),
    .limit_i     (limit_q),
    .expected_i  (expected_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/pxu_front.sv
// Front end: accepts stream bytes, assembles five-byte groups, queues work.
module pxu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  pxu_pkg::in_t    in_data_i,
  input  logic            q_full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output pxu_pkg::qentry_t entry_o
);

  logic [pxu_pkg::PhaseW-1:0]           phase_q, phase_d;
  logic [3:0][pxu_pkg::ByteW-1:0]       bytes_q;
  logic                                 accept;
  logic                                 is_eof;
  logic                                 last_byte;
  logic [pxu_pkg::ByteW-1:0]            b;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_eof     = (in_data_i.req_type == pxu_pkg::REQ_EOF);
  assign last_byte  = (phase_q == pxu_pkg::PhaseW'(pxu_pkg::GroupBytes - 1));
  assign b          = in_data_i.data_byte;

  // Classify: end of frame or group completion produce queue work
  assign push_o = accept && (is_eof || last_byte);

  always_comb begin
    entry_o.op        = is_eof ? pxu_pkg::OP_EOF : pxu_pkg::OP_GROUP;
    entry_o.leftover  = (phase_q != '0);
    entry_o.pixels[0] = {bytes_q[0], bytes_q[1][7:6]};
    entry_o.pixels[1] = {bytes_q[1][5:0], bytes_q[2][7:4]};
    entry_o.pixels[2] = {bytes_q[2][3:0], bytes_q[3][7:2]};
    entry_o.pixels[3] = {bytes_q[3][1:0], b};
  end

  // Group phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (is_eof || last_byte) begin
        phase_d = '0;
      end else begin
        phase_d = phase_q + pxu_pkg::PhaseW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Held group bytes, first four of each group
  always_ff @(posedge clk_i) begin
    if (accept && !is_eof && !last_byte) begin
      bytes_q[phase_q[1:0]] <= b;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= pxu_pkg::PhaseW'(pxu_pkg::GroupBytes - 1))
    else $error("group phase out of range");

endmodule

### sv/pxu_fifo.sv
// Four-entry work queue between the front end and the back end.
module pxu_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pxu_pkg::qentry_t  entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output pxu_pkg::qentry_t  head_o
);

  pxu_pkg::qentry_t              slots_q [pxu_pkg::QDepth];
  logic [pxu_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [pxu_pkg::QCntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == pxu_pkg::QCntW'(pxu_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slots_q[rd_q];

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + pxu_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - pxu_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + pxu_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + pxu_pkg::QPtrW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

### sv/pxu_back.sv
// Back end: counts pixels, emits pixel and end-of-frame results.
module pxu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  pxu_pkg::qentry_t              head_i,
  output logic                          pop_o,
  input  logic                          out_mode_i,
  input  logic [pxu_pkg::LimitW-1:0]    limit_i,
  input  logic [pxu_pkg::ExpW-1:0]      expected_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output pxu_pkg::out_t                 out_data_o
);

  logic [pxu_pkg::CountW-1:0] count_q, count_d, cnt_inc;
  logic [1:0]                 idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;
  pxu_pkg::out_t              out_q, out_d, res;
  logic                       adv, load, emit, more;
  logic [pxu_pkg::PixW-1:0]   px;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Per-cycle step: one pixel of the head group, or one status
  always_comb begin
    adv     = !out_valid_q || !out_stall_i;
    cnt_inc = (count_q == pxu_pkg::CountMax) ? count_q
                                             : count_q + pxu_pkg::CountW'(1);
    emit    = {{(pxu_pkg::LimitW - pxu_pkg::CountW){1'b0}}, count_q} < limit_i;
    more    = {{(pxu_pkg::LimitW - pxu_pkg::CountW){1'b0}}, cnt_inc} < limit_i;
    px      = head_i.pixels[idx_q];
    count_d = count_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    res     = '0;
    if (q_valid_i && adv) begin
      if (head_i.op == pxu_pkg::OP_EOF) begin
        load                = 1'b1;
        res.result_kind     = pxu_pkg::RES_STATUS;
        res.leftover_error  = head_i.leftover;
        res.size_error      = ({{(pxu_pkg::ExpW - pxu_pkg::CountW){1'b0}}, count_q}
                               != expected_i);
        res.received_pixels = count_q;
        res.last            = 1'b1;
        count_d             = '0;
        pop_o               = 1'b1;
      end else begin
        load            = emit;
        res.result_kind = pxu_pkg::RES_PIXEL;
        if (out_mode_i) begin
          res.gray_byte = px[pxu_pkg::PixW-1:2];
        end else begin
          res.pixel_value = px;
        end
        // emitted pixels form a prefix, so last is the final one that passes
        res.last = (idx_q == 2'd3) || !more;
        count_d  = cnt_inc;
        idx_d    = idx_q + 2'd1;
        pop_o    = (idx_q == 2'd3);
      end
    end
    out_valid_d = adv ? load : out_valid_q;
    out_d       = load ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  a_mid_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> q_valid_i && head_i.op == pxu_pkg::OP_GROUP)
    else $error("pixel index advanced without a group at queue head");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.result_kind == pxu_pkg::RES_STATUS |-> out_q.last)
    else $error("end-of-frame status without last");

endmodule

### test/pxu_unpack_checker.sv
`timescale 1ns / 100ps
// Checker for the packed 10-bit pixel unpacker: watches both channels, predicts and compares.
module pxu_unpack_checker
  import pxu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_t                out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  localparam int MaxReports = 10;

  // Shadow copy of the configuration registers
  logic              mode_q;
  logic [DimW-1:0]   width_q;
  logic [DimW-1:0]   height_q;
  logic [ExtraW-1:0] extra_q;

  // Shadow copy of the unpack state
  logic [3:0][ByteW-1:0] held_bytes;
  logic [PhaseW-1:0]     phase_q;
  logic [CountW-1:0]     px_count;

  // Pixels and frame status still owed by the block, oldest first
  out_t pixel_status_q[$];
  int   mismatches;

  // Works out the results of one accepted item and advances the shadow state
  task automatic unpack_item(input in_t item);
    int                   eff_w;
    int                   eff_h;
    int                   want_size;
    int                   limit;
    int                   last_idx;
    logic [3:0]           emit;
    logic [3:0][PixW-1:0] px;
    out_t                 res;
    eff_w = (width_q > MaxWidth) ? int'(MaxWidth) : int'(width_q);
    eff_h = (height_q > MaxHeight) ? int'(MaxHeight) : int'(height_q);
    res   = '0;
    if (item.req_type == REQ_EOF) begin
      // Frame status; adjusted height may go negative
      want_size           = eff_w * (eff_h + int'($signed(extra_q)));
      res.result_kind     = RES_STATUS;
      res.leftover_error  = (phase_q != '0);
      res.size_error      = (int'(px_count) != want_size);
      res.received_pixels = px_count;
      res.last            = 1'b1;
      pixel_status_q.push_back(res);
      phase_q  = '0;
      px_count = '0;
    end else if (phase_q < GroupBytes - 1) begin
      held_bytes[phase_q[1:0]] = item.data_byte;
      phase_q++;
    end else begin
      // Fifth byte closes the group: four MSB-first 10-bit pixels
      px[0]    = {held_bytes[0], held_bytes[1][7:6]};
      px[1]    = {held_bytes[1][5:0], held_bytes[2][7:4]};
      px[2]    = {held_bytes[2][3:0], held_bytes[3][7:2]};
      px[3]    = {held_bytes[3][1:0], item.data_byte};
      limit    = eff_w * eff_h;
      last_idx = -1;
      phase_q  = '0;
      for (int i = 0; i < 4; i++) begin
        emit[i] = (int'(px_count) < limit);
        if (emit[i]) last_idx = i;
        if (px_count != CountMax) px_count++;
      end
      for (int i = 0; i < 4; i++) begin
        if (emit[i]) begin
          res             = '0;
          res.result_kind = RES_PIXEL;
          if (mode_q) res.gray_byte = px[i][PixW-1:2];
          else res.pixel_value = px[i];
          res.last = (i == last_idx);
          pixel_status_q.push_back(res);
        end
      end
    end
  endtask

  // Compares one result transfer with the oldest expectation
  task automatic compare_result(input out_t got);
    out_t want;
    if (pixel_status_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: unexpected kind=%0d pix=%0d gray=%0d lo=%0d sz=%0d cnt=%0d last=%0d",
                 $realtime, got.result_kind, got.pixel_value, got.gray_byte,
                 got.leftover_error, got.size_error, got.received_pixels, got.last);
    end else begin
      want = pixel_status_q.pop_front();
      if (got.result_kind !== want.result_kind || got.pixel_value !== want.pixel_value ||
          got.gray_byte !== want.gray_byte || got.leftover_error !== want.leftover_error ||
          got.size_error !== want.size_error ||
          got.received_pixels !== want.received_pixels || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: mismatch exp kind=%0d pix=%0d gray=%0d lo=%0d sz=%0d cnt=%0d last=%0d",
                   $realtime, want.result_kind, want.pixel_value, want.gray_byte,
                   want.leftover_error, want.size_error, want.received_pixels, want.last);
          $display("%0t:          got kind=%0d pix=%0d gray=%0d lo=%0d sz=%0d cnt=%0d last=%0d",
                   $realtime, got.result_kind, got.pixel_value, got.gray_byte,
                   got.leftover_error, got.size_error, got.received_pixels, got.last);
        end
      end
    end
  endtask

  // Register writes, input transfers and result transfers, sampled at the edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     = 1'b0;
      width_q    = DimW'(RstWidth);
      height_q   = DimW'(RstHeight);
      extra_q    = '0;
      held_bytes = '0;
      phase_q    = '0;
      px_count   = '0;
      mismatches = 0;
      pixel_status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OUT_MODE:     mode_q   = cfg_wdata_i[0];
          CFG_FRAME_WIDTH:  width_q  = cfg_wdata_i[DimW-1:0];
          CFG_FRAME_HEIGHT: height_q = cfg_wdata_i[DimW-1:0];
          CFG_EXTRA_ROWS:   extra_q  = cfg_wdata_i[ExtraW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) unpack_item(in_data_i);
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
    end
    mismatches_o <= mismatches;
    pending_o    <= pixel_status_q.size();
  end

endmodule

### test/packed_10bit_pixel_unpacker_test.sv
`timescale 1ns / 100ps
// Testbench top for the packed 10-bit pixel unpacker: stimulus, stall patterns and verdict.
module packed_10bit_pixel_unpacker_test;
  import pxu_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int LongHold   = 200;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int cycles;
  int items_sent;

  // Sender and receiver pacing
  int tx_run;
  bit tx_idles;
  bit tx_burst;
  int rx_run;
  bit rx_idles;
  bit long_hold_req;

  packed_10bit_pixel_unpacker u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  pxu_unpack_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("packed_10bit_pixel_unpacker verification failed");
      $finish;
    end
  end

  // One input transfer, preceded by a random gap outside bursts; valid stays up afterwards
  task automatic push_item(input req_type_e kind, input logic [ByteW-1:0] b);
    in_t item;
    int  gap;
    item.req_type  = kind;
    item.data_byte = b;
    if (tx_run == 0) begin
      tx_run   = $urandom_range(1, 20);
      tx_idles = $urandom_range(0, 1);
    end
    tx_run--;
    gap = (tx_idles && !tx_burst) ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Whole groups of random bytes, an optional partial tail, then end of frame
  task automatic send_frame(input int n_groups, input int n_tail, input bit with_eof);
    repeat (n_groups * GroupBytes + n_tail) push_item(REQ_DATA, ByteW'($urandom));
    if (with_eof) push_item(REQ_EOF, ByteW'($urandom));
  endtask

  // Drops valid and waits until every predicted result has left the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all four registers while the block is idle
  task automatic program_frame(input logic mode, input logic [DimW-1:0] w,
                               input logic [DimW-1:0] h, input logic signed [ExtraW-1:0] extra);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_OUT_MODE;
    cfg_wdata <= CfgDataW'(mode);
    @(posedge clk);
    cfg_idx   <= CFG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= CFG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_idx   <= CFG_EXTRA_ROWS;
    cfg_wdata <= {{(CfgDataW-ExtraW){1'b0}}, extra};
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Receiver: random stall before each result, one long hold on request
  initial begin : rx_side
    int hold;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LongHold;
      end else begin
        if (rx_run == 0) begin
          rx_run   = $urandom_range(1, 20);
          rx_idles = $urandom_range(0, 1);
        end
        rx_run--;
        hold = rx_idles ? $urandom_range(0, 15) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic                     mode;
    logic [DimW-1:0]          w;
    logic [DimW-1:0]          h;
    logic signed [ExtraW-1:0] extra;
    int                       ew;
    int                       eh;
    int                       target;
    int                       phase_start;
    int                       pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // 2x2 frame of exact size, 10-bit pixel output
    program_frame(1'b0, 12'd2, 12'd2, 7'sd0);
    push_item(REQ_DATA, 8'hFF);
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, 8'hFF);
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, 8'hFF);
    push_item(REQ_EOF, 8'h00);
    // Second group lies past the frame, then a partial group at end of frame
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, 8'hFF);
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, 8'hFF);
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, 8'h12);
    push_item(REQ_DATA, 8'h34);
    push_item(REQ_DATA, 8'h56);
    push_item(REQ_DATA, 8'h78);
    push_item(REQ_DATA, 8'h9A);
    push_item(REQ_DATA, 8'hA5);
    push_item(REQ_DATA, 8'h5A);
    push_item(REQ_EOF, 8'hFF);
    // Empty frame
    push_item(REQ_EOF, 8'h00);

    // 8-bit gray output, oversized width, negative adjusted height
    program_frame(1'b1, 12'd4095, 12'd1, -7'sd64);
    repeat (GroupBytes) push_item(REQ_DATA, 8'hFF);
    push_item(REQ_EOF, 8'h00);

    // Back-to-back groups against a long receiver hold so the block fills up
    program_frame(1'b0, 12'd4095, 12'd4095, 7'sd63);
    long_hold_req = 1'b1;
    tx_burst      = 1'b1;
    send_frame(6, 0, 1'b1);
    tx_burst = 1'b0;

    // Random phases, the first three at the size extremes
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin mode = 1'b1; w = 12'd0;    h = 12'd5;    extra = -7'sd64; end
        1: begin mode = 1'b0; w = 12'd3;    h = 12'd0;    extra = 7'sd0;   end
        2: begin mode = 1'b1; w = 12'd2048; h = 12'd2048; extra = 7'sd8;   end
        default: begin
          mode  = $urandom_range(0, 1);
          w     = $urandom_range(1, 8);
          h     = $urandom_range(1, 4);
          extra = ($urandom_range(0, 3) == 0) ? ExtraW'($urandom)
                                              : ExtraW'($urandom_range(0, 2) - 1);
        end
      endcase
      program_frame(mode, w, h, extra);
      ew          = (w > MaxWidth) ? int'(MaxWidth) : int'(w);
      eh          = (h > MaxHeight) ? int'(MaxHeight) : int'(h);
      target      = ew * (eh + int'(extra));
      phase_start = items_sent;
      while (items_sent - phase_start < 5) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          // Well-formed frame, sized to match when the size allows it
          if (target >= 0 && target % 4 == 0 && target <= 24) send_frame(target / 4, 0, 1'b1);
          else send_frame($urandom_range(0, 3), 0, 1'b1);
        end else if (pick <= 7) begin
          send_frame($urandom_range(0, 2), $urandom_range(1, 4), 1'b1);
        end else if (pick == 8) begin
          repeat ($urandom_range(1, 6))
            push_item(($urandom_range(0, 3) == 0) ? REQ_EOF : REQ_DATA, ByteW'($urandom));
        end else begin
          // Group left open across the next frame boundary or register change
          send_frame($urandom_range(1, 2), $urandom_range(0, 4), 1'b0);
        end
      end
    end

    wait_idle();
    if (mismatches == 0) $display("packed_10bit_pixel_unpacker verification clean");
    else $display("packed_10bit_pixel_unpacker verification failed");
    $finish;
  end

endmodule
